[design/pgw_pkg.sv]
// pgw_pkg: item types, command codes and field constants shared by the
// page table walker front, back and top level; no dependencies
`default_nettype none

package pgw_pkg;

    localparam int ADDR_W   = 52;
    localparam int VADDR_W  = 48;
    localparam int ENTRY_W  = 64;
    localparam int LEVEL_W  = 2;
    localparam int KIND_W   = 2;
    localparam int PSIZE_W  = 2;
    localparam int ACT_W    = 3;
    localparam int PAGE_LSB = 12;

    // input function codes
    localparam logic FUNC_TRANSLATE = 1'b0;
    localparam logic FUNC_ENTRY     = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    // page sizes
    localparam logic [PSIZE_W-1:0] PSIZE_4K = 2'd0;
    localparam logic [PSIZE_W-1:0] PSIZE_2M = 2'd1;
    localparam logic [PSIZE_W-1:0] PSIZE_1G = 2'd2;

    // walk levels
    localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_1G   = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_2M   = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd3;

    // entry bits
    localparam int PRESENT_BIT = 0;
    localparam int HUGE_BIT    = 7;

    // front-to-back command actions
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FAULT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DONE1G = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DONE2M = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DONE4K = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REJECT = 3'd5;

    typedef struct packed {
        logic               func;
        logic [VADDR_W-1:0] virt_addr;
        logic [ENTRY_W-1:0] read_data;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic [ADDR_W-1:0]  read_addr;
        logic [ADDR_W-1:0]  xlat_addr;
        logic               fault;
        logic [LEVEL_W-1:0] fault_level;
        logic [PSIZE_W-1:0] leaf_size;
    } t_out_item;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [LEVEL_W-1:0] level;
        logic [ADDR_W-1:0]  base;
        logic [VADDR_W-1:0] vaddr;
    } t_cmd;

endpackage

`default_nettype wire

[design/pgw_queue.sv]
// pgw_queue: small flop-based first-in first-out queue
// generic width and power-of-two depth; no package dependency
`default_nettype none

module pgw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = wr_en ? PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = rd_en ? PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (wr_en && !rd_en) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (rd_en && !wr_en) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[design/pgw_front.sv]
// pgw_front: walk state, root table register and item classification
// depends on pgw_pkg; emits one command per accepted item
`default_nettype none

module pgw_front #(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pgw_pkg::ADDR_W-1:0]      i_cfg_wdata,
    input  wire logic                            i_accept,
    input  wire pgw_pkg::t_in_item               i_item,
    output pgw_pkg::t_cmd                        o_cmd
);

    localparam int TBL_W = PHYS_ADDR_BITS - pgw_pkg::PAGE_LSB;

    logic [TBL_W-1:0]                r_root;
    logic                            r_busy, n_busy;
    logic [pgw_pkg::LEVEL_W-1:0]     r_level, n_level;
    logic [pgw_pkg::VADDR_W-1:0]     r_vaddr, n_vaddr;
    logic [pgw_pkg::ADDR_W-1:0]      root_base, entry_base;
    logic                            present, huge;

    assign root_base  = pgw_pkg::ADDR_W'({r_root, {pgw_pkg::PAGE_LSB{1'b0}}});
    assign entry_base = pgw_pkg::ADDR_W'({i_item.read_data[PHYS_ADDR_BITS-1:pgw_pkg::PAGE_LSB],
                                          {pgw_pkg::PAGE_LSB{1'b0}}});
    assign present    = i_item.read_data[pgw_pkg::PRESENT_BIT];
    assign huge       = i_item.read_data[pgw_pkg::HUGE_BIT];

    always_comb begin
        n_busy       = r_busy;
        n_level      = r_level;
        n_vaddr      = r_vaddr;
        o_cmd.action = pgw_pkg::ACT_REJECT;
        o_cmd.level  = r_level;
        o_cmd.base   = entry_base;
        o_cmd.vaddr  = r_vaddr;
        if (i_item.func == pgw_pkg::FUNC_TRANSLATE) begin
            if (!r_busy) begin
                n_busy       = 1'b1;
                n_level      = pgw_pkg::LEVEL_TOP;
                n_vaddr      = i_item.virt_addr;
                o_cmd.action = pgw_pkg::ACT_READ;
                o_cmd.level  = pgw_pkg::LEVEL_TOP;
                o_cmd.base   = root_base;
                o_cmd.vaddr  = i_item.virt_addr;
            end
        end else if (r_busy) begin
            priority if (!present) begin
                n_busy       = 1'b0;
                o_cmd.action = pgw_pkg::ACT_FAULT;
            end else if (r_level == pgw_pkg::LEVEL_1G && huge) begin
                n_busy       = 1'b0;
                o_cmd.action = pgw_pkg::ACT_DONE1G;
            end else if (r_level == pgw_pkg::LEVEL_2M && huge) begin
                n_busy       = 1'b0;
                o_cmd.action = pgw_pkg::ACT_DONE2M;
            end else if (r_level == pgw_pkg::LEVEL_LEAF) begin
                n_busy       = 1'b0;
                o_cmd.action = pgw_pkg::ACT_DONE4K;
            end else begin
                n_level      = pgw_pkg::LEVEL_W'(r_level + 1'b1);
                o_cmd.action = pgw_pkg::ACT_READ;
                o_cmd.level  = n_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root  <= '0;
            r_busy  <= 1'b0;
            r_level <= pgw_pkg::LEVEL_TOP;
            r_vaddr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_root <= i_cfg_wdata[PHYS_ADDR_BITS-1:pgw_pkg::PAGE_LSB];
            end
            if (i_accept) begin
                r_busy  <= n_busy;
                r_level <= n_level;
                r_vaddr <= n_vaddr;
            end
        end
    end

    // rejected items leave the walk untouched
    a_reject_keeps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_cmd.action == pgw_pkg::ACT_REJECT) |=> $stable(r_busy))
        else $error("reject changed walk state");

    // a read request always leaves a walk running
    a_read_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_cmd.action == pgw_pkg::ACT_READ) |=> r_busy)
        else $error("read issued without walk running");

    // the level read next is the level the walker then waits on
    a_read_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_cmd.action == pgw_pkg::ACT_READ) |=> (r_level == $past(o_cmd.level)))
        else $error("walk level does not match issued read");

    // any finish ends the walk
    a_done_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (o_cmd.action == pgw_pkg::ACT_FAULT
                   || o_cmd.action == pgw_pkg::ACT_DONE1G
                   || o_cmd.action == pgw_pkg::ACT_DONE2M
                   || o_cmd.action == pgw_pkg::ACT_DONE4K)) |=> !r_busy)
        else $error("walk still busy after finish");

endmodule

`default_nettype wire

[design/pgw_back.sv]
// pgw_back: turns a walker command into a result item
// depends on pgw_pkg; pure address assembly, no state
`default_nettype none

module pgw_back (
    input  wire pgw_pkg::t_cmd       i_cmd,
    output pgw_pkg::t_out_item       o_result
);

    logic [8:0] idx;

    always_comb begin
        unique case (i_cmd.level)
            pgw_pkg::LEVEL_TOP: idx = i_cmd.vaddr[47:39];
            pgw_pkg::LEVEL_1G:  idx = i_cmd.vaddr[38:30];
            pgw_pkg::LEVEL_2M:  idx = i_cmd.vaddr[29:21];
            default:            idx = i_cmd.vaddr[20:12];
        endcase
    end

    always_comb begin
        o_result = '0;
        unique case (i_cmd.action)
            pgw_pkg::ACT_READ: begin
                o_result.result_kind = pgw_pkg::KIND_READ;
                o_result.read_addr   = {i_cmd.base[pgw_pkg::ADDR_W-1:pgw_pkg::PAGE_LSB],
                                        idx, 3'b000};
            end
            pgw_pkg::ACT_FAULT: begin
                o_result.result_kind = pgw_pkg::KIND_DONE;
                o_result.fault       = 1'b1;
                o_result.fault_level = i_cmd.level;
            end
            pgw_pkg::ACT_DONE1G: begin
                o_result.result_kind = pgw_pkg::KIND_DONE;
                o_result.xlat_addr   = {i_cmd.base[pgw_pkg::ADDR_W-1:30], i_cmd.vaddr[29:0]};
                o_result.leaf_size   = pgw_pkg::PSIZE_1G;
            end
            pgw_pkg::ACT_DONE2M: begin
                o_result.result_kind = pgw_pkg::KIND_DONE;
                o_result.xlat_addr   = {i_cmd.base[pgw_pkg::ADDR_W-1:21], i_cmd.vaddr[20:0]};
                o_result.leaf_size   = pgw_pkg::PSIZE_2M;
            end
            pgw_pkg::ACT_DONE4K: begin
                o_result.result_kind = pgw_pkg::KIND_DONE;
                o_result.xlat_addr   = {i_cmd.base[pgw_pkg::ADDR_W-1:pgw_pkg::PAGE_LSB],
                                        i_cmd.vaddr[pgw_pkg::PAGE_LSB-1:0]};
                o_result.leaf_size   = pgw_pkg::PSIZE_4K;
            end
            default: begin
                o_result.result_kind = pgw_pkg::KIND_REJECT;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/four_level_page_table_walker_unit.sv]
// an accepted item's command is written into the command queue; the back turns the
// queue head into a result, which is written into the output queue and popped from there
// throughput: one item per cycle, both queue sides stall independently
// every item gives exactly one result, in order
// reset (synchronous, active low): walker idle, level 0, root table base 0,
// both queues empty; no clearing pass, items are taken right after reset
// depends on pgw_pkg, pgw_queue, pgw_front, pgw_back
`default_nettype none

module four_level_page_table_walker_unit #(
    parameter int PHYS_ADDR_BITS = 52,
    parameter int CMD_DEPTH      = 2,
    parameter int OUT_DEPTH      = 2
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // root table base register
    input  wire logic                        i_cfg_we,
    input  wire logic [pgw_pkg::ADDR_W-1:0]  i_cfg_wdata,
    // item input side
    input  wire logic                        i_push,
    output logic                             o_full,
    input  wire pgw_pkg::t_in_item           i_in_item,
    // result side
    output logic                             o_empty,
    input  wire logic                        i_pop,
    output pgw_pkg::t_out_item               o_out_item
);

    // front: classifies each item against the walk state in the cycle it
    // is accepted, so the next item sees the updated state at once
    logic             accept;
    pgw_pkg::t_cmd    front_cmd;

    // command queue between front and back
    pgw_pkg::t_cmd    back_cmd;
    logic             cmd_empty;

    // back: assembles result fields, pushes into the output queue
    pgw_pkg::t_out_item back_result;
    logic             out_full;
    logic             back_move;

    assign accept    = i_push && !o_full;
    assign back_move = !cmd_empty && !out_full;

    pgw_front #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_cmd       (front_cmd)
    );

    pgw_queue #(
        .WIDTH ($bits(pgw_pkg::t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (o_full),
        .i_pop   (back_move),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    pgw_back u_back (
        .i_cmd    (back_cmd),
        .o_result (back_result)
    );

    // output queue parts the back from the result consumer
    pgw_queue #(
        .WIDTH ($bits(pgw_pkg::t_out_item)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_move),
        .i_data  (back_result),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_out_item),
        .o_empty (o_empty)
    );

    // a rejected item carries nothing but its kind
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out_item.result_kind == pgw_pkg::KIND_REJECT)
        |-> (o_out_item.read_addr == '0 && o_out_item.xlat_addr == '0
             && !o_out_item.fault && o_out_item.leaf_size == pgw_pkg::PSIZE_4K))
        else $error("rejected item carries payload");

    // result kind is never the unused code
    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_out_item.result_kind == pgw_pkg::KIND_READ
                   || o_out_item.result_kind == pgw_pkg::KIND_DONE
                   || o_out_item.result_kind == pgw_pkg::KIND_REJECT))
        else $error("unknown result kind");

    // entry reads are always eight-byte aligned
    a_read_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out_item.result_kind == pgw_pkg::KIND_READ)
        |-> (o_out_item.read_addr[2:0] == 3'b000))
        else $error("misaligned entry read");

endmodule

`default_nettype wire

[test/testbench.sv]
// testbench for four_level_page_table_walker_unit: directed and random page walks,
// each result checked against a cycle-free walk predictor
// depends on pgw_pkg and the walker rtl
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 310;
    localparam logic [pgw_pkg::ADDR_W-1:0] ROOT_ALL_ONES = {pgw_pkg::ADDR_W{1'b1}};

    // what the driver does with the head of its queue
    typedef enum logic [1:0] {
        JOB_ITEM,
        JOB_CFG,
        JOB_DRAIN
    } t_job_kind;

    typedef struct {
        t_job_kind                  kind;
        logic [pgw_pkg::ADDR_W-1:0] cfg_val;
        pgw_pkg::t_in_item          item;
    } t_job;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [pgw_pkg::ADDR_W-1:0] cfg_wdata = '0;
    logic                       push = 1'b0;
    logic                       full;
    pgw_pkg::t_in_item          in_item = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    pgw_pkg::t_out_item         out_item;

    t_job               pending_items[$];
    pgw_pkg::t_out_item walker_answers[$];

    int                 cycle_cnt = 0;
    int                 err_count = 0;
    int                 rand_items = 0;
    logic               quiet;
    logic               drv_fire;
    t_job               drv_job;
    pgw_pkg::t_out_item want_item;

    // predictor state: walk in progress, current level, saved address, root base
    logic                        pw_busy = 1'b0;
    logic [pgw_pkg::LEVEL_W-1:0] pw_level = pgw_pkg::LEVEL_TOP;
    logic [pgw_pkg::VADDR_W-1:0] pw_vaddr = '0;
    logic [pgw_pkg::ADDR_W-1:0]  pw_root = '0;

    four_level_page_table_walker_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_in_item   (in_item),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_item  (out_item)
    );

    always #4 clk = ~clk;

    // a stretch of cycles in which neither side idles
    assign quiet = (cycle_cnt >= 800) && (cycle_cnt < 1600);

    // ------------------------------------------------------------------
    // walk predictor
    // ------------------------------------------------------------------

    // entry address inside a table: table base plus eight times the nine-bit index
    function automatic logic [pgw_pkg::ADDR_W-1:0] table_slot(
            logic [pgw_pkg::ADDR_W-1:0] tbl, logic [pgw_pkg::LEVEL_W-1:0] lvl);
        logic [pgw_pkg::VADDR_W-1:0] shifted;
        shifted = pw_vaddr >> (39 - 9 * lvl);
        return {tbl[pgw_pkg::ADDR_W-1:pgw_pkg::PAGE_LSB], shifted[8:0], 3'b000};
    endfunction

    function automatic pgw_pkg::t_out_item walk_predict(pgw_pkg::t_in_item it);
        pgw_pkg::t_out_item         r;
        logic [pgw_pkg::ADDR_W-1:0] tbl;
        logic                       huge;
        r = '0;
        tbl = {it.read_data[pgw_pkg::ADDR_W-1:pgw_pkg::PAGE_LSB],
               {pgw_pkg::PAGE_LSB{1'b0}}};
        huge = it.read_data[pgw_pkg::HUGE_BIT];
        if (it.func == pgw_pkg::FUNC_TRANSLATE) begin
            // a request while a walk runs is turned away, state untouched
            if (pw_busy) begin
                r.result_kind = pgw_pkg::KIND_REJECT;
            end else begin
                pw_vaddr = it.virt_addr;
                pw_level = pgw_pkg::LEVEL_TOP;
                pw_busy = 1'b1;
                r.result_kind = pgw_pkg::KIND_READ;
                r.read_addr = table_slot({pw_root[pgw_pkg::ADDR_W-1:pgw_pkg::PAGE_LSB],
                                          {pgw_pkg::PAGE_LSB{1'b0}}},
                                         pgw_pkg::LEVEL_TOP);
            end
        end else if (!pw_busy) begin
            // stray entry with no walk open
            r.result_kind = pgw_pkg::KIND_REJECT;
        end else if (!it.read_data[pgw_pkg::PRESENT_BIT]) begin
            pw_busy = 1'b0;
            r.result_kind = pgw_pkg::KIND_DONE;
            r.fault = 1'b1;
            r.fault_level = pw_level;
        end else if (pw_level == pgw_pkg::LEVEL_1G && huge) begin
            pw_busy = 1'b0;
            r.result_kind = pgw_pkg::KIND_DONE;
            r.xlat_addr = {tbl[pgw_pkg::ADDR_W-1:30], pw_vaddr[29:0]};
            r.leaf_size = pgw_pkg::PSIZE_1G;
        end else if (pw_level == pgw_pkg::LEVEL_2M && huge) begin
            pw_busy = 1'b0;
            r.result_kind = pgw_pkg::KIND_DONE;
            r.xlat_addr = {tbl[pgw_pkg::ADDR_W-1:21], pw_vaddr[20:0]};
            r.leaf_size = pgw_pkg::PSIZE_2M;
        end else if (pw_level == pgw_pkg::LEVEL_LEAF) begin
            pw_busy = 1'b0;
            r.result_kind = pgw_pkg::KIND_DONE;
            r.xlat_addr = {tbl[pgw_pkg::ADDR_W-1:pgw_pkg::PAGE_LSB],
                           pw_vaddr[pgw_pkg::PAGE_LSB-1:0]};
            r.leaf_size = pgw_pkg::PSIZE_4K;
        end else begin
            // table pointer, huge bit at the top level ignored
            pw_level = pw_level + 1'b1;
            r.result_kind = pgw_pkg::KIND_READ;
            r.read_addr = table_slot(tbl, pw_level);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        err_count++;
    endtask

    task automatic check_result(pgw_pkg::t_out_item got, pgw_pkg::t_out_item want);
        if (got.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind got %h want %h",
                                      got.result_kind, want.result_kind));
        if (got.read_addr !== want.read_addr)
            report_mismatch($sformatf("read_addr got %h want %h",
                                      got.read_addr, want.read_addr));
        if (got.xlat_addr !== want.xlat_addr)
            report_mismatch($sformatf("xlat_addr got %h want %h",
                                      got.xlat_addr, want.xlat_addr));
        if (got.fault !== want.fault)
            report_mismatch($sformatf("fault got %h want %h", got.fault, want.fault));
        if (got.fault_level !== want.fault_level)
            report_mismatch($sformatf("fault_level got %h want %h",
                                      got.fault_level, want.fault_level));
        if (got.leaf_size !== want.leaf_size)
            report_mismatch($sformatf("leaf_size got %h want %h",
                                      got.leaf_size, want.leaf_size));
    endtask

    // ------------------------------------------------------------------
    // driver: feeds items, register writes and drain points from the queue
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
            cfg_we <= 1'b0;
        end else begin
            drv_fire = push && !full;
            // predict at acceptance so the state follows the accepted order
            if (drv_fire)
                walker_answers.push_back(walk_predict(in_item));
            if (push && !drv_fire) begin
                // item held until the walker takes it
                cfg_we <= 1'b0;
            end else if (pending_items.size() == 0) begin
                push <= 1'b0;
                cfg_we <= 1'b0;
            end else if (pending_items[0].kind != JOB_ITEM) begin
                push <= 1'b0;
                // register writes and drain points wait until the walker is empty
                if (!drv_fire && walker_answers.size() == 0 && empty && !cfg_we) begin
                    drv_job = pending_items.pop_front();
                    if (drv_job.kind == JOB_CFG) begin
                        cfg_we <= 1'b1;
                        cfg_wdata <= drv_job.cfg_val;
                        pw_root = drv_job.cfg_val;
                    end else begin
                        cfg_we <= 1'b0;
                    end
                end else begin
                    cfg_we <= 1'b0;
                end
            end else if (!quiet && $urandom_range(99) < 16) begin
                // sender gap
                push <= 1'b0;
                cfg_we <= 1'b0;
            end else begin
                drv_job = pending_items.pop_front();
                in_item <= drv_job.item;
                push <= 1'b1;
                cfg_we <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: pops results with random stalls and checks them in order
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (walker_answers.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want_item = walker_answers.pop_front();
                    check_result(out_item, want_item);
                end
            end
            pop <= quiet || ($urandom_range(99) >= 16);
        end
    end

    // cycle counter and timeout
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("four_level_page_table_walker_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [pgw_pkg::VADDR_W-1:0] rand_va();
        logic [63:0] v;
        v = rand64();
        return v[pgw_pkg::VADDR_W-1:0];
    endfunction

    // random entry with chosen present and huge bits
    function automatic logic [pgw_pkg::ENTRY_W-1:0] make_entry(logic present, logic huge);
        logic [pgw_pkg::ENTRY_W-1:0] v;
        v = rand64();
        v[pgw_pkg::PRESENT_BIT] = present;
        v[pgw_pkg::HUGE_BIT] = huge;
        return v;
    endfunction

    task automatic add_item(logic func, logic [pgw_pkg::VADDR_W-1:0] va,
                            logic [pgw_pkg::ENTRY_W-1:0] data);
        t_job j;
        j.kind = JOB_ITEM;
        j.cfg_val = '0;
        j.item.func = func;
        j.item.virt_addr = va;
        j.item.read_data = data;
        pending_items.push_back(j);
    endtask

    task automatic add_marker(t_job_kind kind, logic [pgw_pkg::ADDR_W-1:0] val);
        t_job j;
        j.kind = kind;
        j.cfg_val = val;
        j.item = '0;
        pending_items.push_back(j);
    endtask

    // one well-formed walk with random content, now and then a rejected
    // request in the middle or a stray entry after it
    task automatic add_random_walk();
        logic pres;
        logic huge;
        add_item(pgw_pkg::FUNC_TRANSLATE, rand_va(), rand64());
        rand_items++;
        for (int lvl = 0; lvl < 4; lvl++) begin
            if ($urandom_range(99) < 4) begin
                add_item(pgw_pkg::FUNC_TRANSLATE, rand_va(), rand64());
                rand_items++;
            end
            pres = ($urandom_range(99) >= 8);
            huge = ($urandom_range(99) < 30);
            add_item(pgw_pkg::FUNC_ENTRY, rand_va(), make_entry(pres, huge));
            rand_items++;
            if (!pres || lvl == 3 || (huge && (lvl == 1 || lvl == 2)))
                break;
        end
        if ($urandom_range(99) < 5) begin
            add_item(pgw_pkg::FUNC_ENTRY, rand_va(), rand64());
            rand_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence: directed walks, then random phases under several roots
    // ------------------------------------------------------------------
    initial begin
        logic [pgw_pkg::ADDR_W-1:0] roots[5];
        logic [63:0]                rv;

        // root base still at its reset value of zero
        add_item(pgw_pkg::FUNC_ENTRY, '0, {pgw_pkg::ENTRY_W{1'b1}});  // entry while idle
        add_item(pgw_pkg::FUNC_TRANSLATE, '0, '0);
        add_item(pgw_pkg::FUNC_ENTRY, '0, '0);                        // fault at the top

        // all-ones root, low twelve bits must be ignored
        add_marker(JOB_CFG, ROOT_ALL_ONES);
        add_item(pgw_pkg::FUNC_TRANSLATE, {pgw_pkg::VADDR_W{1'b1}}, '0);
        add_item(pgw_pkg::FUNC_ENTRY, '0, {pgw_pkg::ENTRY_W{1'b1}});  // huge at top ignored
        add_item(pgw_pkg::FUNC_ENTRY, '0, {pgw_pkg::ENTRY_W{1'b1}});  // 1 GiB page
        add_item(pgw_pkg::FUNC_TRANSLATE, 48'h8040_2010_0FFF, '0);
        add_item(pgw_pkg::FUNC_TRANSLATE, {pgw_pkg::VADDR_W{1'b1}}, '0);  // request while busy
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h0000_0ABC_DEF0_1001);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h000F_FFFF_FFFF_F001);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'hFFF0_0000_0020_0081);   // 2 MiB page
        add_item(pgw_pkg::FUNC_TRANSLATE, 48'h0000_7FFF_FFFF, '0);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h1);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h1);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h1);
        add_item(pgw_pkg::FUNC_ENTRY, '0, {pgw_pkg::ENTRY_W{1'b1}});  // 4 KiB page
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h1);                     // entry while idle
        add_item(pgw_pkg::FUNC_TRANSLATE, 48'h5A5A_A5A5_3C3C, '0);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h81);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h80);                    // fault at level 1
        add_item(pgw_pkg::FUNC_TRANSLATE, 48'hC3C3_1234_5678, '0);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h1);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h1);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h0);                     // fault at level 2
        add_item(pgw_pkg::FUNC_TRANSLATE, 48'h0123_4567_89AB, '0);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h1);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h1);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'h1);
        add_item(pgw_pkg::FUNC_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FFFE);   // fault at the leaf

        // roots for the random phases: zero, all ones and random values
        roots[0] = '0;
        roots[1] = ROOT_ALL_ONES;
        for (int i = 2; i < 5; i++) begin
            rv = rand64();
            roots[i] = rv[pgw_pkg::ADDR_W-1:0];
        end

        for (int p = 0; p < 5; p++) begin
            add_marker(JOB_CFG, roots[p]);
            rand_items = 0;
            while (rand_items < PHASE_ITEMS) begin
                add_random_walk();
                // midway through the third phase, hold the sender until the walker has drained
                if (p == 2 && rand_items >= PHASE_ITEMS / 2 && rand_items < PHASE_ITEMS / 2 + 6)
                    add_marker(JOB_DRAIN, '0);
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // all stimulus taken, then all results back, then a short tail
        while (pending_items.size() != 0 || push)
            @(posedge clk);
        while (walker_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (err_count == 0) begin
            $display("four_level_page_table_walker_unit verification clean");
        end else begin
            $display("four_level_page_table_walker_unit verification failed");
        end
        $finish;
    end

endmodule

[files.f]
design/pgw_pkg.sv
design/pgw_queue.sv
design/pgw_front.sv
design/pgw_back.sv
design/four_level_page_table_walker_unit.sv
test/testbench.sv
